// File: sv/rmq_pkg.sv
// Package with the beat types and shared constants of the matrix-to-quaternion converter.
package rmq_pkg;

  localparam int FRAC_BITS = 15;
  localparam int DW = 16;
  localparam int SW = 20;
  localparam int RADW = SW + FRAC_BITS;
  localparam int RW = (RADW + 1) / 2;
  localparam int NUMW = 18 + FRAC_BITS;
  localparam int DENW = RW + 1;

  typedef struct packed {
    logic signed [DW-1:0] m00;
    logic signed [DW-1:0] m01;
    logic signed [DW-1:0] m02;
    logic signed [DW-1:0] m10;
    logic signed [DW-1:0] m11;
    logic signed [DW-1:0] m12;
    logic signed [DW-1:0] m20;
    logic signed [DW-1:0] m21;
    logic signed [DW-1:0] m22;
  } rmq_in_t;

  typedef struct packed {
    logic signed [DW-1:0] quat_x;
    logic signed [DW-1:0] quat_y;
    logic signed [DW-1:0] quat_z;
    logic signed [DW-1:0] quat_w;
    logic                 degenerate;
  } rmq_out_t;

  typedef struct packed {
    logic                   degen;
    logic [1:0]             axis;
    logic                   trace_br;
    logic signed [17:0]     d0;
    logic signed [17:0]     d1;
    logic signed [17:0]     d2;
  } rmq_ctl_t;

  function automatic logic signed [DW-1:0] sat16(input logic signed [NUMW:0] v);
    logic signed [NUMW:0] hi;
    logic signed [NUMW:0] lo;
    begin
      hi = (NUMW+1)'(32767);
      lo = -(NUMW+1)'(32768);
      if (v > hi) sat16 = 16'sh7fff;
      else if (v < lo) sat16 = 16'sh8000;
      else sat16 = v[DW-1:0];
    end
  endfunction

endpackage

// File: sv/rotation_matrix_to_quaternion.sv
// Top level of the pipelined rotation-matrix to quaternion converter.
//   channel | ports                       | direction
//   input   | start, in_beat, busy        | in (busy is out)
//   result  | out_strobe, out_beat        | out
// One beat enters per cycle; busy is always low after reset.
// The path runs through the front stage, the root stages, the divider stages and the output register.
// The root and divider pipelines set the latency; throughput is one beat a cycle.
// Synchronous active-low reset clears all valid bits.
// The receiver cannot stall, so the pipeline never holds.
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  rmq_in_t  in_beat,
  output logic     out_strobe,
  output rmq_out_t out_beat
);

  logic            f_vld, s_vld;
  logic [RADW-1:0] f_rad;
  logic [RW-1:0]   s_root;
  rmq_ctl_t        f_ctl, s_ctl;

  assign busy = 1'b0;

  rmq_front u_front (.clk, .rst_n, .in_vld(start), .in_beat,
    .out_vld(f_vld), .out_rad(f_rad), .out_ctl(f_ctl));
  rmq_sqrt u_sqrt (.clk, .rst_n, .in_vld(f_vld), .in_rad(f_rad), .in_ctl(f_ctl),
    .out_vld(s_vld), .out_root(s_root), .out_ctl(s_ctl));
  rmq_div u_div (.clk, .rst_n, .in_vld(s_vld), .in_root(s_root), .in_ctl(s_ctl),
    .out_vld(out_strobe), .out_beat);

  a_busy_low: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_strobe_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(out_strobe))
    else $error("result strobe unknown");

endmodule

// File: sv/rmq_sqrt.sv
// Pipelined restoring square root, one result bit per stage.
module rmq_sqrt
  import rmq_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  logic [RADW-1:0] in_rad,
  input  rmq_ctl_t        in_ctl,
  output logic            out_vld,
  output logic [RW-1:0]   out_root,
  output rmq_ctl_t        out_ctl
);

  localparam int PW = 2 * RW;

  logic [PW-1:0]   rem_r  [RW+1];
  logic [PW-1:0]   rad_r  [RW+1];
  logic [RW-1:0]   root_r [RW+1];
  logic            vld_r  [RW+1];
  rmq_ctl_t        ctl_r  [RW+1];

  always_comb begin
    rem_r[0]  = '0;
    rad_r[0]  = PW'(in_rad);
    root_r[0] = '0;
    vld_r[0]  = in_vld;
    ctl_r[0]  = in_ctl;
  end

  for (genvar g = 0; g < RW; g++) begin : g_st
    logic [PW-1:0] rem_nxt;
    logic [PW-1:0] rem_q;
    logic [PW-1:0] rad_q;
    logic [RW-1:0] root_q;
    logic          vld_q;
    rmq_ctl_t      ctl_q;
    always_comb begin
      rem_nxt = {rem_r[g][PW-3:0], rad_r[g][PW-1:PW-2]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld_r[g];
      end
      rad_q <= rad_r[g] << 2;
      ctl_q <= ctl_r[g];
      if (rem_nxt >= ((PW'(root_r[g]) << 2) | PW'(1))) begin
        rem_q  <= rem_nxt - ((PW'(root_r[g]) << 2) | PW'(1));
        root_q <= {root_r[g][RW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_nxt;
        root_q <= {root_r[g][RW-2:0], 1'b0};
      end
    end
    always_comb begin
      rem_r[g+1]  = rem_q;
      rad_r[g+1]  = rad_q;
      root_r[g+1] = root_q;
      vld_r[g+1]  = vld_q;
      ctl_r[g+1]  = ctl_q;
    end
  end

  assign out_vld  = vld_r[RW];
  assign out_root = root_r[RW];
  assign out_ctl  = ctl_r[RW];

endmodule

// File: sv/rmq_div.sv
// Pipelined restoring divider producing rounded scaled terms for three lanes.
module rmq_div
  import rmq_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [RW-1:0] in_root,
  input  rmq_ctl_t      in_ctl,
  output logic          out_vld,
  output rmq_out_t      out_beat
);

  localparam int QW = NUMW;

  logic [DENW-1:0] den_r  [QW+1];
  logic [RW-1:0]   root_r [QW+1];
  logic [QW-1:0]   num_r  [QW+1][3];
  logic [DENW:0]   rem_r  [QW+1][3];
  logic [QW-1:0]   quo_r  [QW+1][3];
  logic            vld_r  [QW+1];
  rmq_ctl_t        ctl_r  [QW+1];

  always_comb begin
    den_r[0]  = {in_root, 1'b0};
    root_r[0] = in_root;
    vld_r[0]  = in_vld;
    ctl_r[0]  = in_ctl;
    num_r[0][0] = (QW'(in_ctl.d0[17] ? -in_ctl.d0 : in_ctl.d0) << FRAC_BITS) + QW'(in_root);
    num_r[0][1] = (QW'(in_ctl.d1[17] ? -in_ctl.d1 : in_ctl.d1) << FRAC_BITS) + QW'(in_root);
    num_r[0][2] = (QW'(in_ctl.d2[17] ? -in_ctl.d2 : in_ctl.d2) << FRAC_BITS) + QW'(in_root);
    for (int l = 0; l < 3; l++) begin
      rem_r[0][l] = '0;
      quo_r[0][l] = '0;
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_st
    logic [DENW-1:0] den_q;
    logic [RW-1:0]   root_q;
    logic [QW-1:0]   num_q [3];
    logic [DENW:0]   rem_q [3];
    logic [QW-1:0]   quo_q [3];
    logic            vld_q;
    rmq_ctl_t        ctl_q;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld_r[g];
      end
      den_q  <= den_r[g];
      root_q <= root_r[g];
      ctl_q  <= ctl_r[g];
      for (int l = 0; l < 3; l++) begin
        logic [DENW:0] sh;
        sh = {rem_r[g][l][DENW-1:0], num_r[g][l][QW-1]};
        num_q[l] <= num_r[g][l] << 1;
        if (sh >= {1'b0, den_r[g]}) begin
          rem_q[l] <= sh - {1'b0, den_r[g]};
          quo_q[l] <= {quo_r[g][l][QW-2:0], 1'b1};
        end else begin
          rem_q[l] <= sh;
          quo_q[l] <= {quo_r[g][l][QW-2:0], 1'b0};
        end
      end
    end
    always_comb begin
      den_r[g+1]  = den_q;
      root_r[g+1] = root_q;
      vld_r[g+1]  = vld_q;
      ctl_r[g+1]  = ctl_q;
      num_r[g+1]  = num_q;
      rem_r[g+1]  = rem_q;
      quo_r[g+1]  = quo_q;
    end
  end

  logic signed [NUMW:0] sc [3];
  logic signed [NUMW:0] half;
  logic                 neg [3];
  logic signed [NUMW:0] lanes [4];
  rmq_ctl_t             c;
  rmq_out_t             beat_nxt;
  rmq_out_t             beat_r;
  logic                 vld_o_r;

  always_comb begin
    c = ctl_r[QW];
    neg[0] = c.d0[17];
    neg[1] = c.d1[17];
    neg[2] = c.d2[17];
    for (int l = 0; l < 3; l++) begin
      sc[l] = neg[l] ? -$signed({1'b0, quo_r[QW][l]}) : $signed({1'b0, quo_r[QW][l]});
    end
    half = $signed((NUMW+1)'((RW+1)'(root_r[QW]) + (RW+1)'(1)) >>> 1);
    for (int l = 0; l < 4; l++) lanes[l] = '0;
    if (c.trace_br) begin
      lanes[0] = sc[0];
      lanes[1] = sc[1];
      lanes[2] = sc[2];
      lanes[3] = half;
    end else begin
      lanes[3] = sc[0];
      unique case (c.axis)
        2'd0: begin lanes[0] = half; lanes[1] = sc[1]; lanes[2] = sc[2]; end
        2'd1: begin lanes[1] = half; lanes[2] = sc[1]; lanes[0] = sc[2]; end
        default: begin lanes[2] = half; lanes[0] = sc[1]; lanes[1] = sc[2]; end
      endcase
    end
    if (c.degen) begin
      for (int l = 0; l < 4; l++) lanes[l] = '0;
    end
    beat_nxt.quat_x     = sat16(lanes[0]);
    beat_nxt.quat_y     = sat16(lanes[1]);
    beat_nxt.quat_z     = sat16(lanes[2]);
    beat_nxt.quat_w     = sat16(lanes[3]);
    beat_nxt.degenerate = c.degen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o_r <= 1'b0;
    end else begin
      vld_o_r <= vld_r[QW];
    end
    beat_r <= beat_nxt;
  end

  assign out_vld  = vld_o_r;
  assign out_beat = beat_r;

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && out_beat.degenerate |-> out_beat.quat_w == '0 && out_beat.quat_x == '0)
    else $error("degenerate beat with nonzero components");

endmodule

// File: sv/rmq_front.sv
// Front stage: branch choice, radicand and difference terms.
module rmq_front
  import rmq_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  rmq_in_t         in_beat,
  output logic            out_vld,
  output logic [RADW-1:0] out_rad,
  output rmq_ctl_t        out_ctl
);

  logic signed [SW-1:0] tr;
  logic signed [SW-1:0] s;
  logic signed [SW-1:0] one;
  logic signed [SW-1:0] a0, a1, a2;
  logic [1:0]           ax;
  rmq_ctl_t             ctl_nxt;
  rmq_ctl_t             ctl_r;
  logic [RADW-1:0]      rad_r;
  logic                 vld_r;

  always_comb begin
    one = SW'(1) <<< FRAC_BITS;
    a0 = SW'(in_beat.m00);
    a1 = SW'(in_beat.m11);
    a2 = SW'(in_beat.m22);
    tr = a0 + a1 + a2;
    ax = 2'd0;
    if (in_beat.m11 > in_beat.m00) ax = 2'd1;
    if (ax == 2'd1) begin
      if (in_beat.m22 > in_beat.m11) ax = 2'd2;
    end else begin
      if (in_beat.m22 > in_beat.m00) ax = 2'd2;
    end
    ctl_nxt = '0;
    ctl_nxt.axis = ax;
    if (tr > 0) begin
      ctl_nxt.trace_br = 1'b1;
      s = tr + one;
      ctl_nxt.d0 = 18'(in_beat.m12) - 18'(in_beat.m21);
      ctl_nxt.d1 = 18'(in_beat.m20) - 18'(in_beat.m02);
      ctl_nxt.d2 = 18'(in_beat.m01) - 18'(in_beat.m10);
    end else begin
      unique case (ax)
        2'd0: begin
          s = a0 - a1 - a2 + one;
          ctl_nxt.d0 = 18'(in_beat.m12) - 18'(in_beat.m21);
          ctl_nxt.d1 = 18'(in_beat.m01) + 18'(in_beat.m10);
          ctl_nxt.d2 = 18'(in_beat.m02) + 18'(in_beat.m20);
        end
        2'd1: begin
          s = a1 - a2 - a0 + one;
          ctl_nxt.d0 = 18'(in_beat.m20) - 18'(in_beat.m02);
          ctl_nxt.d1 = 18'(in_beat.m12) + 18'(in_beat.m21);
          ctl_nxt.d2 = 18'(in_beat.m10) + 18'(in_beat.m01);
        end
        default: begin
          s = a2 - a0 - a1 + one;
          ctl_nxt.d0 = 18'(in_beat.m01) - 18'(in_beat.m10);
          ctl_nxt.d1 = 18'(in_beat.m20) + 18'(in_beat.m02);
          ctl_nxt.d2 = 18'(in_beat.m21) + 18'(in_beat.m12);
        end
      endcase
      ctl_nxt.degen = (s <= 0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
    ctl_r <= ctl_nxt;
    rad_r <= ctl_nxt.degen ? (RADW'(1) << FRAC_BITS) : (RADW'(s) << FRAC_BITS);
  end

  assign out_vld = vld_r;
  assign out_rad = rad_r;
  assign out_ctl = ctl_r;

endmodule
